// ----- hdl/tstm_pkg.sv -----
package tstm_pkg;

  localparam int STAMP_W = 63;
  localparam int SLOP_W = 32;
  localparam int LIMIT_W = 4;
  localparam int CMD_W = 3;
  localparam int DROP_W = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_SLOP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_COLOR = 3'd0,
    CMD_PUSH_DEPTH = 3'd1,
    CMD_PUSH_INFO  = 3'd2,
    CMD_POP        = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_RESET_ALL  = 3'd5,
    CMD_NOP6       = 3'd6,
    CMD_NOP7       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_TRIM,
    ST_STALE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_REPORT
  } eng_state_t;

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

endpackage

// ----- hdl/three_stream_timestamp_matcher_core.sv -----
// Clear and idle commands go straight to the report state; a push first drops the oldest
// entries of a full cache, and a pop runs the stale trim, entry scan and shift states.
// One command is processed at a time; a two-beat queue decouples the input side.
// Synchronous active-low reset empties all caches, zeroes the drop count and
// restores slop_ns to 20000000 and cache_limit to 8.
module three_stream_timestamp_matcher_core #(
  parameter int CACHE_DEPTH = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tstm_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [tstm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tstm_pkg::CMD_W-1:0]        in_command,
  input  logic [tstm_pkg::STAMP_W-1:0]      in_stamp,
  input  logic [TAG_BITS-1:0]               in_message_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic [TAG_BITS-1:0]               out_color_tag,
  output logic [TAG_BITS-1:0]               out_depth_tag,
  output logic [TAG_BITS-1:0]               out_info_tag,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_color_count,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_depth_count,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_info_count,
  output logic [tstm_pkg::DROP_W-1:0]       out_dropped_count
);
  import tstm_pkg::*;

  localparam int QW = CMD_W + STAMP_W + TAG_BITS;

  logic [SLOP_W-1:0] slop_r;
  logic [LIMIT_W-1:0] limit_r;
  logic q_valid, q_take;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slop_r <= 32'd20000000;
      limit_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOP: slop_r <= cfg_wdata;
        REG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tstm_cmd_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall),
    .wr_data({in_command, in_stamp, in_message_tag}),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  tstm_engine #(.CACHE_DEPTH(CACHE_DEPTH), .TAG_BITS(TAG_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .slop(slop_r), .limit(limit_r),
    .cmd_valid(q_valid), .cmd_take(q_take),
    .cmd(cmd_t'(q_data[QW-1 -: CMD_W])),
    .cmd_stamp(q_data[TAG_BITS +: STAMP_W]),
    .cmd_tag(q_data[TAG_BITS-1:0]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_matched(out_matched), .out_color_tag(out_color_tag),
    .out_depth_tag(out_depth_tag), .out_info_tag(out_info_tag),
    .out_color_count(out_color_count), .out_depth_count(out_depth_count),
    .out_info_count(out_info_count), .out_dropped_count(out_dropped_count)
  );
endmodule

// ----- hdl/tstm_cmd_fifo.sv -----
module tstm_cmd_fifo #(
  parameter int WIDTH = 82,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_take,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_stall = (cnt_r == (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && !wr_stall;
  assign do_rd = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

// ----- hdl/tstm_engine.sv -----
module tstm_engine #(
  parameter int CACHE_DEPTH = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [tstm_pkg::SLOP_W-1:0]       slop,
  input  logic [tstm_pkg::LIMIT_W-1:0]      limit,
  input  logic                              cmd_valid,
  output logic                              cmd_take,
  input  tstm_pkg::cmd_t                    cmd,
  input  logic [tstm_pkg::STAMP_W-1:0]      cmd_stamp,
  input  logic [TAG_BITS-1:0]               cmd_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic [TAG_BITS-1:0]               out_color_tag,
  output logic [TAG_BITS-1:0]               out_depth_tag,
  output logic [TAG_BITS-1:0]               out_info_tag,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_color_count,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_depth_count,
  output logic [tstm_pkg::LIMIT_W-1:0]      out_info_count,
  output logic [tstm_pkg::DROP_W-1:0]       out_dropped_count
);
  import tstm_pkg::*;

  localparam int IW = $clog2(CACHE_DEPTH);
  localparam int FW = $clog2(CACHE_DEPTH + 1);

  logic [STAMP_W-1:0] st_r [3][CACHE_DEPTH];
  logic [TAG_BITS-1:0] tg_r [3][CACHE_DEPTH];
  logic [FW-1:0] fill_r [3];
  logic [DROP_W-1:0] drop_r;

  eng_state_t state_r, state_nxt;
  cmd_t cmd_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [IW-1:0] idx_r;
  logic [1:0] lane_r;
  logic [IW-1:0] best_r [2];
  logic best_ok_r [2];
  logic [SLOP_W-1:0] best_d_r [2];
  logic [IW-1:0] rm_idx_r [3];
  logic rm_en_r [3];

  logic out_valid_r, matched_r;
  logic [TAG_BITS-1:0] ct_r, dt_r, it_r;

  logic [FW-1:0] lim;
  logic [STAMP_W-1:0] ref_s;
  logic [STAMP_W:0] dsub;
  logic [STAMP_W-1:0] dabs;
  logic d_in;
  logic [STAMP_W-1:0] sd_s, si_s;
  logic old_d, old_i;
  logic bsel;
  logic any_empty;

  always_comb begin
    if (limit < 4'd3) begin
      lim = FW'(3);
    end else if ({{(32-LIMIT_W){1'b0}}, limit} > 32'(CACHE_DEPTH)) begin
      lim = FW'(CACHE_DEPTH);
    end else begin
      lim = FW'(limit);
    end
  end

  assign ref_s = st_r[0][0];
  assign dsub = {1'b0, st_r[lane_r][idx_r]} - {1'b0, ref_s};
  assign dabs = dsub[STAMP_W] ? (ref_s - st_r[lane_r][idx_r]) : dsub[STAMP_W-1:0];
  assign d_in = (dabs <= {{(STAMP_W-SLOP_W){1'b0}}, slop});
  assign sd_s = st_r[1][IW'(fill_r[1] - 1'b1)];
  assign si_s = st_r[2][IW'(fill_r[2] - 1'b1)];
  assign old_d = (sd_s < ref_s) && ((ref_s - sd_s) > {{(STAMP_W-SLOP_W){1'b0}}, slop});
  assign old_i = (si_s < ref_s) && ((ref_s - si_s) > {{(STAMP_W-SLOP_W){1'b0}}, slop});
  assign bsel = lane_r[1];
  assign any_empty = (fill_r[0] == '0) || (fill_r[1] == '0) || (fill_r[2] == '0);

  logic stale_head;
  assign stale_head = (fill_r[lane_r] != '0) && (st_r[lane_r][0] < ref_s)
    && ((ref_s - st_r[lane_r][0]) > {{(STAMP_W-SLOP_W){1'b0}}, slop});

  assign cmd_take = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_matched = matched_r;
  assign out_color_tag = ct_r;
  assign out_depth_tag = dt_r;
  assign out_info_tag = it_r;
  assign out_color_count = LIMIT_W'(fill_r[0]);
  assign out_depth_count = LIMIT_W'(fill_r[1]);
  assign out_info_count = LIMIT_W'(fill_r[2]);
  assign out_dropped_count = drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic [1:0] push_lane;
  assign push_lane = 2'(cmd_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_take) begin
          unique case (cmd) inside
            CMD_PUSH_COLOR, CMD_PUSH_DEPTH, CMD_PUSH_INFO: state_nxt = ST_PUSH_TRIM;
            CMD_POP: state_nxt = any_empty ? ST_REPORT : ST_STALE;
            default: state_nxt = ST_REPORT;
          endcase
        end
      end
      ST_PUSH_TRIM: begin
        if (fill_r[push_lane] < lim) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_STALE: begin
        if (!stale_head && lane_r == 2'd2) begin
          if (fill_r[1] == '0 || fill_r[2] == '0) begin
            state_nxt = ST_REPORT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (lane_r == 2'd2 && 32'(idx_r) + 1 >= 32'(fill_r[2])) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (best_ok_r[0] && best_ok_r[1]) begin
          state_nxt = ST_SHIFT;
        end else if (old_d || old_i) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_SHIFT: begin
        if (!rm_en_r[0] && !rm_en_r[1] && !rm_en_r[2]) begin
          state_nxt = (matched_r || any_empty) ? ST_REPORT : ST_STALE;
        end
      end
      ST_REPORT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      fill_r[2] <= '0;
      drop_r <= '0;
      out_valid_r <= 1'b0;
      matched_r <= 1'b0;
      lane_r <= '0;
      idx_r <= '0;
      rm_en_r[0] <= 1'b0;
      rm_en_r[1] <= 1'b0;
      rm_en_r[2] <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid && cmd_take) begin
            cmd_r <= cmd;
            stamp_r <= cmd_stamp;
            tag_r <= cmd_tag;
            matched_r <= 1'b0;
            ct_r <= '0;
            dt_r <= '0;
            it_r <= '0;
            lane_r <= 2'd1;
            idx_r <= '0;
            if (cmd == CMD_CLEAR || cmd == CMD_RESET_ALL) begin
              fill_r[0] <= '0;
              fill_r[1] <= '0;
              fill_r[2] <= '0;
            end
            if (cmd == CMD_RESET_ALL) begin
              drop_r <= '0;
            end
          end
        end
        ST_PUSH_TRIM: begin
          if (fill_r[push_lane] >= lim) begin
            for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
              st_r[push_lane][i] <= st_r[push_lane][i+1];
              tg_r[push_lane][i] <= tg_r[push_lane][i+1];
            end
            fill_r[push_lane] <= fill_r[push_lane] - 1'b1;
            if (drop_r != DROP_MAX) drop_r <= drop_r + 1'b1;
          end else begin
            st_r[push_lane][IW'(fill_r[push_lane])] <= stamp_r;
            tg_r[push_lane][IW'(fill_r[push_lane])] <= tag_r;
            fill_r[push_lane] <= fill_r[push_lane] + 1'b1;
          end
        end
        ST_STALE: begin
          if (stale_head) begin
            for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
              st_r[lane_r][i] <= st_r[lane_r][i+1];
              tg_r[lane_r][i] <= tg_r[lane_r][i+1];
            end
            fill_r[lane_r] <= fill_r[lane_r] - 1'b1;
            if (drop_r != DROP_MAX) drop_r <= drop_r + 1'b1;
          end else if (lane_r == 2'd1) begin
            lane_r <= 2'd2;
          end else begin
            lane_r <= 2'd1;
            idx_r <= '0;
            best_ok_r[0] <= 1'b0;
            best_ok_r[1] <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (d_in && (!best_ok_r[bsel] || dabs[SLOP_W-1:0] < best_d_r[bsel])) begin
            best_ok_r[bsel] <= 1'b1;
            best_d_r[bsel] <= dabs[SLOP_W-1:0];
            best_r[bsel] <= idx_r;
          end
          if (32'(idx_r) + 1 >= 32'(fill_r[lane_r])) begin
            idx_r <= '0;
            lane_r <= 2'd2;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DECIDE: begin
          rm_idx_r[0] <= '0;
          rm_idx_r[1] <= best_r[0];
          rm_idx_r[2] <= best_r[1];
          if (best_ok_r[0] && best_ok_r[1]) begin
            matched_r <= 1'b1;
            ct_r <= tg_r[0][0];
            dt_r <= tg_r[1][best_r[0]];
            it_r <= tg_r[2][best_r[1]];
            rm_en_r[0] <= 1'b1;
            rm_en_r[1] <= 1'b1;
            rm_en_r[2] <= 1'b1;
          end else if (old_d || old_i) begin
            rm_en_r[0] <= 1'b1;
            if (drop_r != DROP_MAX) drop_r <= drop_r + 1'b1;
          end
          lane_r <= 2'd1;
        end
        ST_SHIFT: begin
          for (int l = 0; l < 3; l++) begin
            if (rm_en_r[l]) begin
              for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
                if (IW'(i) >= rm_idx_r[l]) begin
                  st_r[l][i] <= st_r[l][i+1];
                  tg_r[l][i] <= tg_r[l][i+1];
                end
              end
              fill_r[l] <= fill_r[l] - 1'b1;
              rm_en_r[l] <= 1'b0;
            end
          end
        end
        ST_REPORT: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ----- hdl/tstm_checker.sv -----
module tstm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_matched,
  input logic [15:0] out_color_tag,
  input logic [3:0]  out_color_count
);
  property p_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid;
  endproperty
  assert property (p_hold) else $error("result beat dropped under stall");

  property p_zero_tag;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_matched |-> out_color_tag == 16'd0;
  endproperty
  assert property (p_zero_tag) else $error("tag not zero without match");

  property p_count;
    @(posedge clk) disable iff (!rst_n) out_valid |-> out_color_count <= 4'd8;
  endproperty
  assert property (p_count) else $error("color count beyond depth");

  property p_reset;
    @(posedge clk) !rst_n |=> !out_valid;
  endproperty
  assert property (p_reset) else $error("result beat after reset");
endmodule

bind three_stream_timestamp_matcher_core tstm_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_matched(out_matched), .out_color_tag(out_color_tag),
  .out_color_count(out_color_count)
);
